// File: hw/rtl/corner_bevel_subdivider_assert.svh
// Assertion macros used by the corner bevel subdivider controller.
`ifndef CORNER_BEVEL_SUBDIVIDER_ASSERT_SVH
`define CORNER_BEVEL_SUBDIVIDER_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define CBS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define CBS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/cbs_pkg.sv
// Types, constants and command structs of the corner bevel subdivider.
`timescale 1ns / 1ps
`default_nettype none
package cbs_pkg;

    localparam int COORD_W        = 32;
    localparam int DIST_W         = 31;
    localparam int LEVELS_W       = 3;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 31;
    localparam int MAX_LEVELS_DEF = 6;
    localparam int SQRT_ITERS     = 32;
    localparam int DIV_ITERS      = 31;
    localparam int ITER_W         = 5;

    localparam logic [DIST_W-1:0]   BEVEL_DIST_RST = 31'd6554;
    localparam logic [LEVELS_W-1:0] LEVELS_RST     = 3'd1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [DIST_W-1:0]         dist_t;
    typedef coord_t [2:0]              vec3_t;
    typedef logic [1:0]                axis_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BEVEL_DISTANCE = 1'b0,
        REG_SUBDIV_LEVELS  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_A    = 2'd0,
        PH_B    = 2'd1,
        PH_DIST = 2'd2
    } phase_t;

    typedef struct packed {
        coord_t prev_x;
        coord_t prev_y;
        coord_t prev_z;
        coord_t corner_x;
        coord_t corner_y;
        coord_t corner_z;
        coord_t next_x;
        coord_t next_y;
        coord_t next_z;
    } in_beat_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        coord_t out_z;
        logic   last_point;
    } out_beat_t;

    // Deferred right subtree: (a, b, next) and its distance
    typedef struct packed {
        vec3_t pa;
        vec3_t pb;
        vec3_t pn;
        dist_t span;
    } frame_t;

    typedef struct packed {
        logic   load_in;
        logic   diff;
        logic   scale;
        logic   sq_mul;
        logic   sq_acc;
        logic   sqrt_start;
        logic   d_mul;
        logic   div_start;
        logic   apply;
        logic   push;
        logic   pop_rd;
        logic   pop_ld;
        logic   out_load_a;
        logic   out_load_b;
        logic   out_last;
        phase_t phase;
        axis_t  axis;
    } dp_cmd_t;

    typedef struct packed {
        logic unit_done;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/corner_bevel_subdivider.sv
// Each leaf node forms two offset points, each with a 32-step square root and three
// 31-step divides; each inner node also forms the next distance.
// L levels give 2^(L-1) - 1 inner and 2^(L-1) leaf nodes and two output points per leaf;
// each resumed subtree is popped from the frame stack, and one corner is taken at a time.
// Reset (aresetn, synchronous, active low) returns to idle with an empty frame stack and
// restores bevel_distance to 6554 and subdivision_levels to 1.
`timescale 1ns / 1ps
`default_nettype none
module corner_bevel_subdivider import cbs_pkg::*; #(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_beat_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_beat_t                  m_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    dist_t               bevel_distance_reg;
    logic [LEVELS_W-1:0] levels_reg;
    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [AW-1:0]       frame_addr;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bevel_distance_reg <= BEVEL_DIST_RST;
            levels_reg         <= LEVELS_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BEVEL_DISTANCE: bevel_distance_reg <= cfg_data[DIST_W-1:0];
                REG_SUBDIV_LEVELS:  levels_reg         <= cfg_data[LEVELS_W-1:0];
                default: ;
            endcase
        end
    end

    cbs_ctrl #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .levels_cfg(levels_reg),
        .cmd       (cmd),
        .stat      (stat),
        .frame_addr(frame_addr)
    );

    cbs_datapath #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .in_data       (s_data),
        .bevel_distance(bevel_distance_reg),
        .frame_addr    (frame_addr),
        .out_data      (m_data)
    );

endmodule
`default_nettype wire

// File: hw/rtl/cbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: hw/rtl/cbs_datapath.sv
// Datapath: point registers, shared multiplier, iterative sqrt and divider, frame stack.
`timescale 1ns / 1ps
`default_nettype none
module cbs_datapath import cbs_pkg::*; #(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    localparam int AW        = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire dp_cmd_t   cmd,
    output dp_stat_t       stat,
    input  wire in_beat_t  in_data,
    input  wire dist_t     bevel_distance,
    input  wire logic [AW-1:0] frame_addr,
    output out_beat_t      out_data
);

    vec3_t p_reg, c_reg, n_reg, a_reg, b_reg;
    dist_t dist_reg;
    logic [2:0][32:0] diff_reg;
    logic [2:0][30:0] mag_reg;
    logic             shift_reg;
    logic [61:0]      prod_reg;
    logic [63:0]      sum_reg;
    logic [63:0]      sq_src_reg;
    logic [33:0]      sq_rem_reg;
    logic [31:0]      root_reg;
    logic [31:0]      div_rem_reg;
    logic [30:0]      div_lo_reg;
    logic [30:0]      quot_reg;
    logic [ITER_W-1:0] iter_reg;
    logic             sq_busy_reg, div_busy_reg;
    out_beat_t        out_reg;

    logic [2:0][32:0] diff_c;
    logic [2:0][31:0] abs_c;
    logic             big_c;
    logic [30:0]      mul_a, mul_b;
    logic [61:0]      prod_c;
    logic [35:0]      sq_rem2, sq_trial;
    logic [32:0]      div_rem2;
    logic [62:0]      dividend;
    logic [30:0]      q_c;
    logic [33:0]      offs_c, apply_sum;
    coord_t           apply_c;
    dist_t            nd_c;
    frame_t           wr_frame, rd_frame;

    // Difference of the selected point pair, per axis
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            unique case (cmd.phase)
                PH_A:    diff_c[i] = {p_reg[i][31], p_reg[i]} - {c_reg[i][31], c_reg[i]};
                PH_B:    diff_c[i] = {n_reg[i][31], n_reg[i]} - {c_reg[i][31], c_reg[i]};
                default: diff_c[i] = {b_reg[i][31], b_reg[i]} - {a_reg[i][31], a_reg[i]};
            endcase
        end
    end

    // Magnitudes and the one-bit scale that brings them below 2^31
    always_comb begin
        big_c = 1'b0;
        for (int i = 0; i < 3; i++) begin
            logic [32:0] neg;
            neg      = ~diff_reg[i] + 33'd1;
            abs_c[i] = diff_reg[i][32] ? neg[31:0] : diff_reg[i][31:0];
            big_c    = big_c | abs_c[i][31];
        end
    end

    // Shared multiplier
    assign mul_a  = mag_reg[cmd.axis];
    assign mul_b  = cmd.d_mul ? dist_reg : mag_reg[cmd.axis];
    assign prod_c = mul_a * mul_b;

    // One root bit per step
    assign sq_rem2  = {sq_rem_reg, sq_src_reg[63:62]};
    assign sq_trial = {2'b00, root_reg, 2'b01};

    // One quotient bit per step
    assign div_rem2 = {div_rem_reg, div_lo_reg[30]};
    assign dividend = {1'b0, prod_reg} + {32'd0, root_reg[31:1]};

    // Offset applied to the corner, saturated to 32 bits
    always_comb begin
        q_c       = (root_reg == 32'd0) ? 31'd0 : quot_reg;
        offs_c    = diff_reg[cmd.axis][32] ? (34'd0 - {3'b000, q_c}) : {3'b000, q_c};
        apply_sum = {{2{c_reg[cmd.axis][31]}}, c_reg[cmd.axis]} + offs_c;
        if (apply_sum[33:31] == 3'b000 || apply_sum[33:31] == 3'b111) begin
            apply_c = apply_sum[31:0];
        end else if (apply_sum[33]) begin
            apply_c = 32'sh8000_0000;
        end else begin
            apply_c = 32'sh7FFF_FFFF;
        end
    end

    // Next distance: length rescaled, divided by four
    assign nd_c = shift_reg ? root_reg[31:1] : {1'b0, root_reg[31:2]};

    assign wr_frame = '{pa: a_reg, pb: b_reg, pn: n_reg, span: nd_c};

    cbs_ram #(
        .WIDTH($bits(frame_t)),
        .DEPTH(MAX_LEVELS)
    ) u_stack (
        .aclk (aclk),
        .we   (cmd.push),
        .waddr(frame_addr),
        .wdata(wr_frame),
        .raddr(frame_addr),
        .rdata(rd_frame)
    );

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            p_reg    <= {in_data.prev_z, in_data.prev_y, in_data.prev_x};
            c_reg    <= {in_data.corner_z, in_data.corner_y, in_data.corner_x};
            n_reg    <= {in_data.next_z, in_data.next_y, in_data.next_x};
            dist_reg <= bevel_distance;
        end
        if (cmd.pop_ld) begin
            p_reg    <= rd_frame.pa;
            c_reg    <= rd_frame.pb;
            n_reg    <= rd_frame.pn;
            dist_reg <= rd_frame.span;
        end
        if (cmd.push) begin
            c_reg    <= a_reg;
            n_reg    <= b_reg;
            dist_reg <= nd_c;
        end
        if (cmd.diff) begin
            diff_reg <= diff_c;
        end
        if (cmd.scale) begin
            shift_reg <= big_c;
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= big_c ? abs_c[i][31:1] : abs_c[i][30:0];
            end
        end
        if (cmd.sq_mul || cmd.d_mul) begin
            prod_reg <= prod_c;
        end
        if (cmd.sq_acc) begin
            sum_reg <= ((cmd.axis == 2'd0) ? 64'd0 : sum_reg) + {2'b00, prod_reg};
        end
        if (cmd.sqrt_start) begin
            sq_src_reg <= sum_reg;
            sq_rem_reg <= '0;
            root_reg   <= '0;
        end else if (sq_busy_reg) begin
            sq_src_reg <= {sq_src_reg[61:0], 2'b00};
            if (sq_rem2 >= sq_trial) begin
                sq_rem_reg <= 34'(sq_rem2 - sq_trial);
                root_reg   <= {root_reg[30:0], 1'b1};
            end else begin
                sq_rem_reg <= sq_rem2[33:0];
                root_reg   <= {root_reg[30:0], 1'b0};
            end
        end
        if (cmd.div_start) begin
            div_rem_reg <= dividend[62:31];
            div_lo_reg  <= dividend[30:0];
            quot_reg    <= '0;
        end else if (div_busy_reg) begin
            div_lo_reg <= {div_lo_reg[29:0], 1'b0};
            if (div_rem2 >= {1'b0, root_reg}) begin
                div_rem_reg <= 32'(div_rem2 - {1'b0, root_reg});
                quot_reg    <= {quot_reg[29:0], 1'b1};
            end else begin
                div_rem_reg <= div_rem2[31:0];
                quot_reg    <= {quot_reg[29:0], 1'b0};
            end
        end
        if (cmd.apply) begin
            if (cmd.phase == PH_A) begin
                a_reg[cmd.axis] <= apply_c;
            end else begin
                b_reg[cmd.axis] <= apply_c;
            end
        end
        if (cmd.out_load_a) begin
            out_reg <= '{out_x: a_reg[0], out_y: a_reg[1], out_z: a_reg[2],
                         last_point: cmd.out_last};
        end
        if (cmd.out_load_b) begin
            out_reg <= '{out_x: b_reg[0], out_y: b_reg[1], out_z: b_reg[2],
                         last_point: cmd.out_last};
        end
    end

    // Iteration control of the sqrt and divide units
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_busy_reg  <= 1'b0;
            div_busy_reg <= 1'b0;
            iter_reg     <= '0;
        end else if (cmd.sqrt_start) begin
            sq_busy_reg <= 1'b1;
            iter_reg    <= '0;
        end else if (cmd.div_start) begin
            div_busy_reg <= 1'b1;
            iter_reg     <= '0;
        end else if (stat.unit_done) begin
            sq_busy_reg  <= 1'b0;
            div_busy_reg <= 1'b0;
        end else if (sq_busy_reg || div_busy_reg) begin
            iter_reg <= iter_reg + ITER_W'(1);
        end
    end

    assign stat.unit_done = (sq_busy_reg && iter_reg == ITER_W'(SQRT_ITERS - 1))
                         || (div_busy_reg && iter_reg == ITER_W'(DIV_ITERS - 1));

    assign out_data = out_reg;

endmodule
`default_nettype wire

// File: hw/rtl/cbs_ctrl.sv
// Controller: sequences the node arithmetic, the frame stack and the point output.
`timescale 1ns / 1ps
`default_nettype none
module cbs_ctrl import cbs_pkg::*; #(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    localparam int AW        = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1,
    localparam int LW        = $clog2(MAX_LEVELS + 1),
    localparam int NW        = MAX_LEVELS + 1
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire logic [LEVELS_W-1:0] levels_cfg,
    output dp_cmd_t                  cmd,
    input  wire dp_stat_t            stat,
    output logic [AW-1:0]            frame_addr
);

`include "corner_bevel_subdivider_assert.svh"

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIFF, ST_SCALE, ST_SQ_MUL, ST_SQ_ACC, ST_SQRT_GO, ST_SQRT_WAIT,
        ST_D_MUL, ST_DIV_GO, ST_DIV_WAIT, ST_APPLY, ST_PUSH, ST_EMIT_A, ST_EMIT_B,
        ST_POP_RD, ST_POP_LD
    } state_t;

    state_t          state_reg, state_next;
    phase_t          phase_reg, phase_next;
    axis_t           axis_reg, axis_next;
    logic [LW-1:0]   level_reg, level_next;
    logic [AW-1:0]   depth_reg, depth_next;
    logic [NW-1:0]   n_reg, n_next, total_reg, total_next;
    logic            m_valid_reg, m_valid_next;
    logic [LW-1:0]   levels_eff;
    logic [NW-1:0]   n_inc;

    // Level of the subtree that starts after leaf pair number leaves
    function automatic logic [LW-1:0] resume_level(input logic [NW-2:0] leaves);
        logic [LW-1:0] tz;
        tz = '0;
        for (int i = NW - 2; i >= 0; i--) begin
            if (leaves[i]) begin
                tz = LW'(i);
            end
        end
        return tz + LW'(1);
    endfunction

    // Clamp the configured depth to 1..MAX_LEVELS
    always_comb begin
        if (levels_cfg == '0) begin
            levels_eff = LW'(1);
        end else if (int'(levels_cfg) > MAX_LEVELS) begin
            levels_eff = LW'(MAX_LEVELS);
        end else begin
            levels_eff = LW'(levels_cfg);
        end
    end

    assign n_inc = n_reg + NW'(1);

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        axis_next    = axis_reg;
        level_next   = level_reg;
        depth_next   = depth_reg;
        n_next       = n_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.phase    = phase_reg;
        cmd.axis     = axis_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    level_next  = levels_eff;
                    total_next  = NW'(1) << levels_eff;
                    n_next      = '0;
                    depth_next  = '0;
                    phase_next  = PH_A;
                    state_next  = ST_DIFF;
                end
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                axis_next  = 2'd0;
                state_next = ST_SQ_MUL;
            end
            ST_SQ_MUL: begin
                cmd.sq_mul = 1'b1;
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC: begin
                cmd.sq_acc = 1'b1;
                if (axis_reg == 2'd2) begin
                    axis_next  = 2'd0;
                    state_next = ST_SQRT_GO;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQRT_GO: begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (stat.unit_done) begin
                    state_next = (phase_reg == PH_DIST) ? ST_PUSH : ST_D_MUL;
                end
            end
            ST_D_MUL: begin
                cmd.d_mul  = 1'b1;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (stat.unit_done) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd.apply = 1'b1;
                if (axis_reg != 2'd2) begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_D_MUL;
                end else if (phase_reg == PH_A) begin
                    phase_next = PH_B;
                    state_next = ST_DIFF;
                end else if (level_reg > LW'(1)) begin
                    phase_next = PH_DIST;
                    state_next = ST_DIFF;
                end else begin
                    cmd.out_load_a = 1'b1;
                    cmd.out_last   = (n_inc == total_reg);
                    m_valid_next   = 1'b1;
                    state_next     = ST_EMIT_A;
                end
            end
            ST_PUSH: begin
                cmd.push   = 1'b1;
                depth_next = depth_reg + AW'(1);
                level_next = level_reg - LW'(1);
                phase_next = PH_A;
                state_next = ST_DIFF;
            end
            ST_EMIT_A: begin
                if (m_ready) begin
                    cmd.out_load_b = 1'b1;
                    cmd.out_last   = (n_inc + NW'(1) == total_reg);
                    n_next         = n_inc;
                    state_next     = ST_EMIT_B;
                end
            end
            ST_EMIT_B: begin
                if (m_ready) begin
                    n_next       = n_inc;
                    m_valid_next = 1'b0;
                    if (depth_reg == '0 || n_inc >= total_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        depth_next = depth_reg - AW'(1);
                        level_next = resume_level(n_inc[NW-1:1]);
                        state_next = ST_POP_RD;
                    end
                end
            end
            ST_POP_RD: begin
                cmd.pop_rd = 1'b1;
                state_next = ST_POP_LD;
            end
            ST_POP_LD: begin
                cmd.pop_ld = 1'b1;
                phase_next = PH_A;
                state_next = ST_DIFF;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_A;
            axis_reg    <= 2'd0;
            level_reg   <= LW'(1);
            depth_reg   <= '0;
            n_reg       <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            axis_reg    <= axis_next;
            level_reg   <= level_next;
            depth_reg   <= depth_next;
            n_reg       <= n_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign frame_addr = depth_reg;

    `CBS_ASSERT_IMPL(a_idle_no_point, aclk, aresetn, s_ready, !m_valid_reg, "new corner with point pending")
    `CBS_ASSERT_IMPL(a_depth_range, aclk, aresetn, 1'b1, int'(depth_reg) < MAX_LEVELS, "stack overflow")
    `CBS_ASSERT_NEXT(a_b_follows_a, aclk, aresetn, state_reg == ST_EMIT_A && m_ready, state_reg == ST_EMIT_B && m_valid_reg, "point b not offered")
    `CBS_ASSERT_IMPL(a_level_nonzero, aclk, aresetn, state_reg != ST_IDLE, level_reg != '0, "level reached zero")
    `CBS_ASSERT_IMPL(a_done_in_wait, aclk, aresetn, stat.unit_done, state_reg == ST_SQRT_WAIT || state_reg == ST_DIV_WAIT, "unit done outside wait")

endmodule
`default_nettype wire
